### rtl/blitter_pixel_expander_defines.svh
// Assertion macros for the blitter pixel expander.
`ifndef BLITTER_PIXEL_EXPANDER_DEFINES_SVH
`define BLITTER_PIXEL_EXPANDER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define BPE_ASSERT_IMPLY(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bpe: assertion failed");
// Next-cycle implication.
`define BPE_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bpe: assertion failed");
`else
`define BPE_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BPE_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif

`endif

### rtl/bpe_pkg.sv
// Types, codes and helpers shared by the blitter pixel expander.
package bpe_pkg;

  typedef enum logic [2:0] {
    REG_ACTION      = 3'd0,
    REG_SRC_FORMAT  = 3'd1,
    REG_TGT_FORMAT  = 3'd2,
    REG_TRANSPARENT = 3'd3,
    REG_SOLID       = 3'd4,
    REG_ROW_WIDTH   = 3'd5,
    REG_TGT_STRIDE  = 3'd6
  } reg_index_t;

  localparam logic [1:0] ACT_COPY  = 2'd0;
  localparam logic [1:0] ACT_MASK  = 2'd1;
  localparam logic [1:0] ACT_SOLID = 2'd2;

  localparam logic [1:0] SRC_BYTE   = 2'd0;
  localparam logic [1:0] SRC_NIBBLE = 2'd1;
  localparam logic [1:0] SRC_BITS   = 2'd2;

  localparam logic [1:0] TGT_BYTE = 2'd0;
  localparam logic [1:0] TGT_HIGH = 2'd1;
  localparam logic [1:0] TGT_LOW  = 2'd2;

  localparam int QUEUE_DEPTH = 4;
  localparam int PTR_BITS    = 2;

  typedef struct packed {
    logic [1:0]  action;
    logic [1:0]  src_format;
    logic [1:0]  tgt_format;
    logic [7:0]  transparent;
    logic [7:0]  solid;
    logic [15:0] row_width;
    logic [15:0] tgt_stride;
  } cfg_t;

  // One source byte as queued: the byte and which of its pixels get written.
  typedef struct packed {
    logic [7:0] src_byte;
    logic [7:0] keep;
  } item_t;

  typedef struct packed {
    logic emit;
    logic emit_last;
    logic pop;
  } back_status_t;

  function automatic logic [7:0] pixel_value(input logic [1:0] fmt, input logic [7:0] b,
                                             input logic [2:0] p);
    logic [7:0] v;
    unique case (fmt)
      SRC_BYTE:   v = b;
      SRC_NIBBLE: v = (p == 3'd0) ? {4'h0, b[7:4]} : {4'h0, b[3:0]};
      default:    v = {7'd0, b[3'd7 - p]};
    endcase
    return v;
  endfunction

  function automatic logic [2:0] lowest_set(input logic [7:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = 7; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

endpackage

### rtl/bpe_front.sv
// Front end: row and column tracking, transparency classification of each byte.
module bpe_front
  import bpe_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   accept,
  input  logic [7:0]             src_byte,
  input  logic                   first_of_blit,
  output logic                   q_push,
  output logic [OFFSET_BITS-1:0] q_base,
  output item_t                  q_item
);

  logic [15:0]            column_pixels;
  logic [OFFSET_BITS-1:0] row_base;

  logic [15:0]            cp;
  logic [OFFSET_BITS-1:0] rb;
  logic                   codes_ok;
  logic [3:0]             ppb;
  logic [15:0]            row_pixels;
  logic [16:0]            col;
  logic [7:0]             keep;
  logic [7:0]             v;

  always_comb begin
    cp       = first_of_blit ? 16'd0 : column_pixels;
    rb       = first_of_blit ? '0 : row_base;
    codes_ok = (cfg.action != 2'd3) && (cfg.src_format != 2'd3) && (cfg.tgt_format != 2'd3);
    unique case (cfg.src_format)
      SRC_BYTE: begin
        ppb        = 4'd1;
        row_pixels = cfg.row_width;
      end
      SRC_NIBBLE: begin
        ppb        = 4'd2;
        row_pixels = {cfg.row_width[15:1], 1'b0};
      end
      default: begin
        ppb        = 4'd8;
        row_pixels = {cfg.row_width[15:3], 3'b000};
      end
    endcase
    col = {1'b0, cp} + 17'(ppb);
    for (int p = 0; p < 8; p++) begin
      v       = pixel_value(cfg.src_format, src_byte, 3'(p));
      keep[p] = (4'(p) < ppb) && ((cfg.action == ACT_COPY) || (v != cfg.transparent));
    end
  end

  assign q_push          = accept && codes_ok && (keep != 8'd0);
  assign q_base          = rb + OFFSET_BITS'(cp);
  assign q_item.src_byte = src_byte;
  assign q_item.keep     = keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_pixels <= 16'd0;
      row_base      <= '0;
    end else if (accept) begin
      if (!codes_ok) begin
        column_pixels <= cp;
        row_base      <= rb;
      end else if (col >= {1'b0, row_pixels}) begin
        column_pixels <= 16'd0;
        row_base      <= rb + OFFSET_BITS'(cfg.tgt_stride);
      end else begin
        column_pixels <= col[15:0];
        row_base      <= rb;
      end
    end
  end

endmodule

### rtl/bpe_queue.sv
// Short queue of classified bytes between front and back.
module bpe_queue
  import bpe_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  logic [OFFSET_BITS-1:0] push_base,
  input  item_t                  push_item,
  output logic                   full,
  input  logic                   pop,
  output logic [OFFSET_BITS-1:0] head_base,
  output item_t                  head_item,
  output logic                   empty
);

  logic [OFFSET_BITS-1:0] base_mem [QUEUE_DEPTH];
  item_t                  item_mem [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]    wr_ptr;
  logic [PTR_BITS-1:0]    rd_ptr;
  logic [PTR_BITS:0]      count;
  logic                   do_push;
  logic                   do_pop;

  assign full      = (count == (PTR_BITS+1)'(QUEUE_DEPTH));
  assign empty     = (count == '0);
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;
  assign head_base = base_mem[rd_ptr];
  assign head_item = item_mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      base_mem[wr_ptr] <= push_base;
      item_mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/bpe_back.sv
// Back end: walks the kept pixels of the head byte, one result item per cycle while the output is popped.
module bpe_back
  import bpe_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   q_empty,
  input  logic [OFFSET_BITS-1:0] head_base,
  input  item_t                  head_item,
  output back_status_t           status,
  output logic                   empty,
  input  logic                   pop,
  output logic [OFFSET_BITS-1:0] tgt_offset,
  output logic [7:0]             pixel_data,
  output logic                   write_high,
  output logic                   write_low,
  output logic                   last
);

  logic       out_valid;
  logic [7:0] done;

  logic [7:0] remaining;
  logic [2:0] p;
  logic [7:0] sel;
  logic [7:0] after;
  logic       px_last;
  logic       advance;
  logic [7:0] v;
  logic [7:0] c;
  logic [7:0] data;
  logic       wh;
  logic       wl;

  always_comb begin
    remaining = head_item.keep & ~done;
    p         = lowest_set(remaining);
    sel       = 8'd1 << p;
    after     = remaining & ~sel;
    px_last   = (after == 8'd0);
    advance   = !q_empty && (!out_valid || pop);
    v         = pixel_value(cfg.src_format, head_item.src_byte, p);
    if (cfg.action == ACT_SOLID) begin
      c = ((cfg.tgt_format == TGT_BYTE) && (cfg.src_format != SRC_NIBBLE))
          ? cfg.solid : {4'h0, cfg.solid[3:0]};
    end else begin
      c = v;
    end
    unique case (cfg.tgt_format)
      TGT_HIGH: begin
        data = {c[3:0], 4'h0};
        wh   = 1'b1;
        wl   = 1'b0;
      end
      TGT_LOW: begin
        data = {4'h0, c[3:0]};
        wh   = 1'b0;
        wl   = 1'b1;
      end
      default: begin
        data = c;
        wh   = 1'b1;
        wl   = 1'b1;
      end
    endcase
  end

  assign status.emit      = advance;
  assign status.emit_last = advance && px_last;
  assign status.pop       = advance && px_last;
  assign empty            = !out_valid;

  always_ff @(posedge clk) begin
    if (advance) begin
      tgt_offset <= head_base + OFFSET_BITS'(p);
      pixel_data <= data;
      write_high <= wh;
      write_low  <= wl;
      last       <= px_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      done      <= 8'd0;
    end else if (advance) begin
      out_valid <= 1'b1;
      done      <= px_last ? 8'd0 : (done | sel);
    end else if (pop) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/blitter_pixel_expander.sv
// Blitter pixel expander top level: config registers, front, queue and back.
//
// Source bytes go in through a queue-style push port and come out as target
// pixel writes (offset, data, nibble mask, last-of-byte) on a queue-style pop
// port. A byte is accepted whenever the four-entry byte queue has room; the
// back end then issues one pixel write per cycle through its output register
// while the pop port keeps taking them, so a byte yields as many writes as it
// has kept pixels: one for byte format, up to two for nibble pairs, up to
// eight for bit format. Bytes whose pixels are all transparent only advance
// the position and are not queued. The single result port is the throughput
// limit. Configuration is written through cfg_valid/cfg_ready/cfg_index/
// cfg_data and must only change while no item is in flight.
`include "blitter_pixel_expander_defines.svh"

module blitter_pixel_expander
  import bpe_pkg::*;
#(
  parameter int OFFSET_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [2:0]             cfg_index,
  input  logic [15:0]            cfg_data,
  input  logic                   push,
  output logic                   full,
  input  logic [7:0]             src_byte,
  input  logic                   first_of_blit,
  output logic                   empty,
  input  logic                   pop,
  output logic [OFFSET_BITS-1:0] tgt_offset,
  output logic [7:0]             pixel_data,
  output logic                   write_high,
  output logic                   write_low,
  output logic                   last
);

  cfg_t                   cfg;
  logic                   accept;
  logic                   q_push;
  logic [OFFSET_BITS-1:0] q_base;
  item_t                  q_item;
  logic                   q_full;
  logic                   q_empty;
  logic [OFFSET_BITS-1:0] head_base;
  item_t                  head_item;
  back_status_t           back_status;

  assign cfg_ready = 1'b1;
  assign full      = q_full;
  assign accept    = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ACTION:      cfg.action      <= cfg_data[1:0];
        REG_SRC_FORMAT:  cfg.src_format  <= cfg_data[1:0];
        REG_TGT_FORMAT:  cfg.tgt_format  <= cfg_data[1:0];
        REG_TRANSPARENT: cfg.transparent <= cfg_data[7:0];
        REG_SOLID:       cfg.solid       <= cfg_data[7:0];
        REG_ROW_WIDTH:   cfg.row_width   <= cfg_data;
        REG_TGT_STRIDE:  cfg.tgt_stride  <= cfg_data;
        default: ;
      endcase
    end
  end

  bpe_front #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .accept       (accept),
    .src_byte     (src_byte),
    .first_of_blit(first_of_blit),
    .q_push       (q_push),
    .q_base       (q_base),
    .q_item       (q_item)
  );

  bpe_queue #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_base(q_base),
    .push_item(q_item),
    .full     (q_full),
    .pop      (back_status.pop),
    .head_base(head_base),
    .head_item(head_item),
    .empty    (q_empty)
  );

  bpe_back #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_empty   (q_empty),
    .head_base (head_base),
    .head_item (head_item),
    .status    (back_status),
    .empty     (empty),
    .pop       (pop),
    .tgt_offset(tgt_offset),
    .pixel_data(pixel_data),
    .write_high(write_high),
    .write_low (write_low),
    .last      (last)
  );

  `BPE_ASSERT_IMPLY(a_emit_needs_item, clk, rst, back_status.emit, !q_empty)
  `BPE_ASSERT_IMPLY(a_last_pops, clk, rst, back_status.emit_last, back_status.pop)
  `BPE_ASSERT_NEXT(a_push_lands, clk, rst, q_push, !q_empty)
  `BPE_ASSERT_NEXT(a_emit_shows, clk, rst, back_status.emit, !empty)

endmodule

### tb/tb_top.sv
// Self-checking testbench for the blitter pixel expander: queue-driven stimulus, in-line predictor.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bpe_pkg::*;

  localparam int OFFSET_BITS = 24;
  localparam int RANDOM_BYTES = 40;
  localparam int SETTLE_CYCLES = 30;
  localparam logic [1:0] CODE_INVALID = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd7;

  typedef struct packed {
    logic [7:0] value;
    logic       first;
  } src_item_t;

  typedef struct packed {
    logic [OFFSET_BITS-1:0] offset;
    logic [7:0]             data;
    logic                   high;
    logic                   low;
    logic                   last;
  } pixel_write_t;

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [2:0]             cfg_index = '0;
  logic [15:0]            cfg_data = '0;
  logic                   push = 1'b0;
  logic                   full;
  logic [7:0]             src_byte = '0;
  logic                   first_of_blit = 1'b0;
  logic                   empty;
  logic                   pop = 1'b0;
  logic [OFFSET_BITS-1:0] tgt_offset;
  logic [7:0]             pixel_data;
  logic                   write_high;
  logic                   write_low;
  logic                   last;

  blitter_pixel_expander #(.OFFSET_BITS(OFFSET_BITS)) i_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .push(push), .full(full), .src_byte(src_byte), .first_of_blit(first_of_blit),
    .empty(empty), .pop(pop),
    .tgt_offset(tgt_offset), .pixel_data(pixel_data),
    .write_high(write_high), .write_low(write_low), .last(last)
  );

  cfg_t                   cfg_shadow = '0;
  logic [15:0]            column = '0;
  logic [OFFSET_BITS-1:0] row_base = '0;

  src_item_t    pending_bytes[$];
  pixel_write_t predicted_writes[$];
  src_item_t    next_byte;
  pixel_write_t oldest_write;

  int bytes_queued = 0;
  int bytes_accepted = 0;
  int writes_checked = 0;
  int error_count = 0;
  int send_idle_pct = 22;
  int recv_idle_pct = 74;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("tb_top: errors");
    $finish;
  end

  // Pixel writes caused by one accepted source byte.
  task automatic expand_byte(input logic [7:0] b, input logic first);
    int unsigned  per_byte;
    logic [15:0]  row_pixels;
    logic [16:0]  next_col;
    logic [7:0]   v;
    logic [7:0]   c;
    pixel_write_t w;
    pixel_write_t held;
    logic         have_held;
    have_held = 1'b0;
    held = '0;
    if (first) begin
      column = '0;
      row_base = '0;
    end
    if (cfg_shadow.action == CODE_INVALID || cfg_shadow.src_format == CODE_INVALID ||
        cfg_shadow.tgt_format == CODE_INVALID) return;
    case (cfg_shadow.src_format)
      SRC_BYTE: begin
        per_byte = 1;
        row_pixels = cfg_shadow.row_width;
      end
      SRC_NIBBLE: begin
        per_byte = 2;
        row_pixels = {cfg_shadow.row_width[15:1], 1'b0};
      end
      default: begin
        per_byte = 8;
        row_pixels = {cfg_shadow.row_width[15:3], 3'b000};
      end
    endcase
    for (int p = 0; p < per_byte; p++) begin
      case (cfg_shadow.src_format)
        SRC_BYTE:   v = b;
        SRC_NIBBLE: v = (p == 0) ? {4'h0, b[7:4]} : {4'h0, b[3:0]};
        default:    v = {7'd0, b[7-p]};
      endcase
      if (cfg_shadow.action != ACT_COPY && v == cfg_shadow.transparent) continue;
      if (cfg_shadow.action == ACT_SOLID) begin
        if (cfg_shadow.tgt_format == TGT_BYTE && cfg_shadow.src_format != SRC_NIBBLE) begin
          c = cfg_shadow.solid;
        end else begin
          c = {4'h0, cfg_shadow.solid[3:0]};
        end
      end else begin
        c = v;
      end
      case (cfg_shadow.tgt_format)
        TGT_BYTE: begin
          w.data = c;
          w.high = 1'b1;
          w.low  = 1'b1;
        end
        TGT_HIGH: begin
          w.data = {c[3:0], 4'h0};
          w.high = 1'b1;
          w.low  = 1'b0;
        end
        default: begin
          w.data = {4'h0, c[3:0]};
          w.high = 1'b0;
          w.low  = 1'b1;
        end
      endcase
      w.offset = row_base + OFFSET_BITS'(column) + OFFSET_BITS'(p);
      w.last = 1'b0;
      if (have_held) predicted_writes.push_back(held);
      held = w;
      have_held = 1'b1;
    end
    if (have_held) begin
      held.last = 1'b1;
      predicted_writes.push_back(held);
    end
    next_col = {1'b0, column} + 17'(per_byte);
    if (next_col >= {1'b0, row_pixels}) begin
      column = '0;
      row_base = row_base + OFFSET_BITS'(cfg_shadow.tgt_stride);
    end else begin
      column = next_col[15:0];
    end
  endtask

  // Driver: push port.
  always @(posedge clk) begin
    if (rst) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        expand_byte(src_byte, first_of_blit);
        bytes_accepted++;
      end
      if (!push || !full) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          next_byte = pending_bytes.pop_front();
          push <= 1'b1;
          src_byte <= next_byte.value;
          first_of_blit <= next_byte.first;
        end else begin
          push <= 1'b0;
          src_byte <= 8'($urandom);
          first_of_blit <= 1'($urandom);
        end
      end
    end
  end

  // Monitor: pop port.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        if (predicted_writes.size() == 0) begin
          $error("unexpected pixel write: offset %h data %h", tgt_offset, pixel_data);
          error_count++;
        end else begin
          oldest_write = predicted_writes.pop_front();
          writes_checked++;
          if (tgt_offset !== oldest_write.offset) begin
            $error("tgt_offset: expected %h, got %h", oldest_write.offset, tgt_offset);
            error_count++;
          end
          if (pixel_data !== oldest_write.data) begin
            $error("pixel_data: expected %h, got %h", oldest_write.data, pixel_data);
            error_count++;
          end
          if (write_high !== oldest_write.high) begin
            $error("write_high: expected %b, got %b", oldest_write.high, write_high);
            error_count++;
          end
          if (write_low !== oldest_write.low) begin
            $error("write_low: expected %b, got %b", oldest_write.low, write_low);
            error_count++;
          end
          if (last !== oldest_write.last) begin
            $error("last: expected %b, got %b", oldest_write.last, last);
            error_count++;
          end
        end
      end
      pop <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic wait_idle();
    do @(posedge clk);
    while (bytes_accepted != bytes_queued || predicted_writes.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] value);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_ACTION:      cfg_shadow.action = value[1:0];
      REG_SRC_FORMAT:  cfg_shadow.src_format = value[1:0];
      REG_TGT_FORMAT:  cfg_shadow.tgt_format = value[1:0];
      REG_TRANSPARENT: cfg_shadow.transparent = value[7:0];
      REG_SOLID:       cfg_shadow.solid = value[7:0];
      REG_ROW_WIDTH:   cfg_shadow.row_width = value;
      REG_TGT_STRIDE:  cfg_shadow.tgt_stride = value;
      default: ;
    endcase
  endtask

  // Narrow registers get random upper data bits, which must be ignored.
  task automatic config_all(input logic [1:0] act, input logic [1:0] src, input logic [1:0] tgt,
                            input logic [7:0] transp, input logic [7:0] colour,
                            input logic [15:0] width, input logic [15:0] stride);
    write_reg(REG_ACTION, {14'($urandom), act});
    write_reg(REG_SRC_FORMAT, {14'($urandom), src});
    write_reg(REG_TGT_FORMAT, {14'($urandom), tgt});
    write_reg(REG_TRANSPARENT, {8'($urandom), transp});
    write_reg(REG_SOLID, {8'($urandom), colour});
    write_reg(REG_ROW_WIDTH, width);
    write_reg(REG_TGT_STRIDE, stride);
  endtask

  task automatic send_byte(input logic [7:0] value, input logic first);
    pending_bytes.push_back('{value, first});
    bytes_queued++;
  endtask

  initial begin : stimulus
    int          random_items;
    int          run_len;
    int unsigned r;
    logic [1:0]  act;
    logic [1:0]  src;
    logic [1:0]  tgt;
    logic [7:0]  transp;
    logic [15:0] width;
    logic [15:0] stride;
    logic [7:0]  b;
    random_items = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // reset config: byte copy, empty rows
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    write_reg(REG_UNUSED, 16'hFFFF);
    send_byte(8'h5A, 1'b0);
    config_all(ACT_COPY, SRC_NIBBLE, TGT_HIGH, 8'h00, 8'h00, 16'd5, 16'hFFFF);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'hF0, 1'b0);
    config_all(ACT_MASK, SRC_BITS, TGT_BYTE, 8'h00, 8'hFF, 16'd17, 16'd3);
    send_byte(8'h00, 1'b1);
    send_byte(8'h81, 1'b0);
    send_byte(8'hFF, 1'b0);
    config_all(ACT_SOLID, SRC_BITS, TGT_BYTE, 8'h01, 8'hC3, 16'd8, 16'd2);
    send_byte(8'h0F, 1'b1);
    send_byte(8'h00, 1'b0);
    config_all(ACT_SOLID, SRC_NIBBLE, TGT_BYTE, 8'h0F, 8'hAB, 16'd4, 16'd10);
    send_byte(8'hF1, 1'b1);
    send_byte(8'h1F, 1'b0);
    config_all(ACT_SOLID, SRC_BYTE, TGT_LOW, 8'h80, 8'hFF, 16'd3, 16'd1);
    send_byte(8'h80, 1'b1);
    send_byte(8'h7F, 1'b0);
    config_all(ACT_MASK, SRC_BYTE, TGT_HIGH, 8'hFF, 8'h00, 16'hFFFF, 16'hFFFF);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h12, 1'b0);
    // invalid codes, one field at a time
    config_all(CODE_INVALID, SRC_BYTE, TGT_BYTE, 8'h00, 8'h00, 16'd2, 16'd5);
    send_byte(8'h55, 1'b0);
    send_byte(8'h66, 1'b1);
    write_reg(REG_ACTION, {14'd0, ACT_COPY});
    write_reg(REG_SRC_FORMAT, {14'd0, CODE_INVALID});
    send_byte(8'h77, 1'b0);
    write_reg(REG_SRC_FORMAT, {14'd0, SRC_BYTE});
    write_reg(REG_TGT_FORMAT, {14'd0, CODE_INVALID});
    send_byte(8'h88, 1'b0);
    write_reg(REG_TGT_FORMAT, {14'd0, TGT_BYTE});
    send_byte(8'h99, 1'b0);

    // offset wrap: fully transparent rows walk row_base past 2^24
    config_all(ACT_MASK, SRC_BITS, TGT_LOW, 8'h00, 8'h00, 16'd8, 16'hFFFF);
    send_byte(8'h00, 1'b1);
    repeat (257) send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h96, 1'b0);

    while (random_items < RANDOM_BYTES) begin
      if (random_items >= 2 * RANDOM_BYTES / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end else if (random_items >= RANDOM_BYTES / 3) begin
        send_idle_pct = 74;
        recv_idle_pct = 22;
      end
      r = $urandom_range(99);
      act = (r < 4) ? CODE_INVALID : 2'($urandom_range(2));
      r = $urandom_range(99);
      src = (r < 4) ? CODE_INVALID : 2'($urandom_range(2));
      r = $urandom_range(99);
      tgt = (r < 4) ? CODE_INVALID : 2'($urandom_range(2));
      case (src)
        SRC_NIBBLE: transp = 8'($urandom_range(15));
        SRC_BITS:   transp = 8'($urandom_range(1));
        default:    transp = 8'($urandom_range(255));
      endcase
      r = $urandom_range(99);
      width = (r < 10) ? 16'd0 : (r < 20) ? 16'hFFFF : 16'($urandom_range(40));
      r = $urandom_range(99);
      stride = (r < 10) ? 16'hFFFF : (r < 20) ? 16'd0 : 16'($urandom_range(64));
      config_all(act, src, tgt, transp, 8'($urandom), width, stride);
      run_len = $urandom_range(1, 8);
      for (int i = 0; i < run_len; i++) begin
        b = 8'($urandom);
        case (src)
          SRC_NIBBLE: begin
            if ($urandom_range(9) < 3) b[7:4] = transp[3:0];
            if ($urandom_range(9) < 3) b[3:0] = transp[3:0];
          end
          SRC_BITS: if ($urandom_range(9) < 2) b = {8{transp[0]}};
          default:  if ($urandom_range(9) < 3) b = transp;
        endcase
        if (i == 0) begin
          send_byte(b, $urandom_range(9) < 7);
        end else begin
          send_byte(b, $urandom_range(49) == 0);
        end
        random_items++;
      end
    end

    wait_idle();
    $display("summary: %0d source bytes, %0d pixel writes checked", bytes_accepted,
             writes_checked);
    $display("summary: copy/mask/solid, all format pairs, invalid codes, offset wrap");
    if (error_count == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
